/* hdl/bmrs_pkg.sv */
// shared types, codes and constants of the block map read segmenter
// no dependencies; every other file of the block imports this package
package bmrs_pkg;

    // fixed field widths
    localparam int unsigned LG_W      = 5;
    localparam int unsigned BLOCK_W   = 20;
    localparam int unsigned IDX_W     = 10;
    localparam int unsigned BYTE_W    = 32;
    localparam int unsigned PHYS_W    = 36;
    localparam int unsigned SEGLEN_W  = 17;
    localparam int unsigned WITHIN_W  = 16;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned PADDR_W   = 3;
    localparam int unsigned PDATA_W   = 32;

    // defaults of the module parameters
    localparam int unsigned TABLE_DEPTH_DEF  = 1024;
    localparam int unsigned MAX_SEGMENTS_DEF = 64;

    // configuration
    localparam logic [LG_W-1:0]   LG_MAX       = 5'd16;
    localparam logic [LG_W-1:0]   LG_RESET     = 5'd12;
    localparam logic [BYTE_W-1:0] STREAM_RESET = 32'd0;

    // register indexes (paddr[2])
    localparam logic REG_BLOCK_SIZE_LOG2 = 1'b0;
    localparam logic REG_STREAM_SIZE     = 1'b1;

    // input commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_STREAM = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd2;

    typedef struct packed {
        logic                command;
        logic [IDX_W-1:0]    entry_index;
        logic [BLOCK_W-1:0]  block_number;
        logic [BYTE_W-1:0]   offset;
        logic [BYTE_W-1:0]   length;
    } req_t;

    typedef struct packed {
        logic [PHYS_W-1:0]   data_offset;
        logic [BYTE_W-1:0]   dest_offset;
        logic [SEGLEN_W-1:0] segment_length;
        logic                last;
        logic [STATUS_W-1:0] status;
    } seg_t;

    // live configuration handed to the sequencer
    typedef struct packed {
        logic [LG_W-1:0]   lg;
        logic [BYTE_W-1:0] stream_size;
    } cfg_t;

    // table access strobes from the sequencer
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } tbl_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_PLAN,
        ST_FETCH,
        ST_EMIT,
        ST_ERROR
    } state_t;

endpackage

/* hdl/block_map_read_segmenter.sv */
// top level of the block map read segmenter
// load: the table entry is written on the request beat. read: a check state and a
// plan state, then per segment a table read (fetch) followed by emit, which holds
// while the output register is full; an error result comes from the error state,
// entered from check on a stream overrun, from plan on a table or segment count overrun
// the walk is paced by the single read port of the block table
// reset: block_size_log2 = 12, stream_size = 0, no result pending; table contents
// stay undefined until loaded, with no clearing pass
module block_map_read_segmenter #(
    parameter int unsigned TABLE_DEPTH  = bmrs_pkg::TABLE_DEPTH_DEF,
    parameter int unsigned MAX_SEGMENTS = bmrs_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bmrs_pkg::PADDR_W-1:0] paddr,
    input  logic [bmrs_pkg::PDATA_W-1:0] pwdata,
    output logic [bmrs_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  bmrs_pkg::req_t               req,
    output logic                         seg_valid,
    input  logic                         seg_ready,
    output bmrs_pkg::seg_t               seg
);
    import bmrs_pkg::*;

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    cfg_t               cfg;
    tbl_ctl_t           tbl_ctl;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    logic [BLOCK_W-1:0] rd_data;

    // configuration registers
    bmrs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // block table memory
    bmrs_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .ctl     (tbl_ctl),
        .wr_addr (wr_addr),
        .wr_data (req.block_number),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // request sequencer and segment output
    bmrs_seq #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .AW           (AW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .seg_valid (seg_valid),
        .seg_ready (seg_ready),
        .seg       (seg),
        .tbl_ctl   (tbl_ctl),
        .wr_addr   (wr_addr),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    // a read request beat blocks further requests until its walk is done
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req.command == CMD_READ) |=> !req_ready)
        else $error("request taken during a read walk");

    // error results are single, empty and final
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid && (seg.status != STATUS_OK) |->
            seg.last && (seg.segment_length == '0) && (seg.data_offset == '0))
        else $error("malformed error result");

    // no segment is longer than one block
    a_seg_len: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid |-> (seg.segment_length <= (SEGLEN_W'(1) << cfg.lg)))
        else $error("segment longer than a block");

    // table is never written and read in the same cycle
    a_tbl_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(tbl_ctl.wr_en && tbl_ctl.rd_en))
        else $error("table write and read overlap");

endmodule

/* hdl/bmrs_table.sv */
// block table: single write port, one registered read port
// depends on bmrs_pkg
module bmrs_table #(
    parameter int unsigned DEPTH = bmrs_pkg::TABLE_DEPTH_DEF,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                         clk,
    input  bmrs_pkg::tbl_ctl_t           ctl,
    input  logic [AW-1:0]                wr_addr,
    input  logic [bmrs_pkg::BLOCK_W-1:0] wr_data,
    input  logic [AW-1:0]                rd_addr,
    output logic [bmrs_pkg::BLOCK_W-1:0] rd_data
);
    import bmrs_pkg::*;

    logic [BLOCK_W-1:0] mem [DEPTH];
    logic [BLOCK_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/bmrs_cfg.sv */
// configuration registers behind the apb-style port
// depends on bmrs_pkg
module bmrs_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bmrs_pkg::PADDR_W-1:0] paddr,
    input  logic [bmrs_pkg::PDATA_W-1:0] pwdata,
    output logic [bmrs_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output bmrs_pkg::cfg_t               cfg
);
    import bmrs_pkg::*;

    logic [LG_W-1:0]   lg_reg;
    logic [BYTE_W-1:0] stream_reg;
    logic              wr_beat;
    logic              reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_beat = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lg_reg     <= LG_RESET;
            stream_reg <= STREAM_RESET;
        end
        else if (wr_beat)
        begin
            if (reg_sel == REG_BLOCK_SIZE_LOG2)
            begin
                lg_reg <= pwdata[LG_W-1:0];
            end
            else
            begin
                stream_reg <= pwdata;
            end
        end
    end

    // read back
    always_comb
    begin
        if (reg_sel == REG_STREAM_SIZE)
        begin
            prdata = stream_reg;
        end
        else
        begin
            prdata = {{(PDATA_W-LG_W){1'b0}}, lg_reg};
        end
    end

    // block size above the limit acts as the limit
    assign cfg.lg          = (lg_reg > LG_MAX) ? LG_MAX : lg_reg;
    assign cfg.stream_size = stream_reg;

endmodule

/* hdl/bmrs_seq.sv */
// sequencer: range checks, table walk and segment output register
// depends on bmrs_pkg; drives the strobes of bmrs_table
module bmrs_seq #(
    parameter int unsigned TABLE_DEPTH  = bmrs_pkg::TABLE_DEPTH_DEF,
    parameter int unsigned MAX_SEGMENTS = bmrs_pkg::MAX_SEGMENTS_DEF,
    parameter int unsigned AW           = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bmrs_pkg::cfg_t               cfg,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  bmrs_pkg::req_t               req,
    output logic                         seg_valid,
    input  logic                         seg_ready,
    output bmrs_pkg::seg_t               seg,
    output bmrs_pkg::tbl_ctl_t           tbl_ctl,
    output logic [AW-1:0]                wr_addr,
    output logic [AW-1:0]                rd_addr,
    input  logic [bmrs_pkg::BLOCK_W-1:0] rd_data
);
    import bmrs_pkg::*;

    localparam int unsigned CW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

    state_t              state_reg, state_next;
    logic                out_valid_reg, out_valid_next;
    seg_t                out_reg, out_next;
    logic [BYTE_W-1:0]   offset_reg, offset_next;
    logic [BYTE_W-1:0]   length_reg, length_next;
    logic [BYTE_W:0]     end_reg, end_next;
    logic [BYTE_W-1:0]   first_reg, first_next;
    logic [BYTE_W-1:0]   last_blk_reg, last_blk_next;
    logic [STATUS_W-1:0] err_reg, err_next;
    logic [AW-1:0]       blk_reg, blk_next;
    logic [WITHIN_W-1:0] within_reg, within_next;
    logic [BYTE_W-1:0]   remaining_reg, remaining_next;
    logic [BYTE_W-1:0]   dest_reg, dest_next;
    logic [CW-1:0]       left_reg, left_next;

    logic                out_free;
    logic [BYTE_W-1:0]   idx_ext;
    logic [BYTE_W-1:0]   span;
    logic [BYTE_W-1:0]   end_byte;
    logic [SEGLEN_W-1:0] bsize;
    logic [SEGLEN_W-1:0] room;
    logic [SEGLEN_W-1:0] seg_len;
    logic [PHYS_W-1:0]   phys;

    assign idx_ext   = BYTE_W'(req.entry_index);
    assign wr_addr   = idx_ext[AW-1:0];
    assign rd_addr   = blk_reg;
    assign out_free  = !out_valid_reg || seg_ready;
    assign req_ready = (state_reg == ST_IDLE);
    assign seg_valid = out_valid_reg;
    assign seg       = out_reg;

    // segment arithmetic
    assign bsize    = SEGLEN_W'(1) << cfg.lg;
    assign room     = bsize - SEGLEN_W'(within_reg);
    assign seg_len  = (remaining_reg < BYTE_W'(room)) ? remaining_reg[SEGLEN_W-1:0] : room;
    assign phys     = (PHYS_W'(rd_data) << cfg.lg) | PHYS_W'(within_reg);
    assign span     = last_blk_reg - first_reg;
    assign end_byte = (length_reg == '0) ? offset_reg : (end_reg[BYTE_W-1:0] - BYTE_W'(1));

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        out_reg       <= out_next;
        offset_reg    <= offset_next;
        length_reg    <= length_next;
        end_reg       <= end_next;
        first_reg     <= first_next;
        last_blk_reg  <= last_blk_next;
        err_reg       <= err_next;
        blk_reg       <= blk_next;
        within_reg    <= within_next;
        remaining_reg <= remaining_next;
        dest_reg      <= dest_next;
        left_reg      <= left_next;
    end

    // next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !seg_ready;
        out_next       = out_reg;
        offset_next    = offset_reg;
        length_next    = length_reg;
        end_next       = end_reg;
        first_next     = first_reg;
        last_blk_next  = last_blk_reg;
        err_next       = err_reg;
        blk_next       = blk_reg;
        within_next    = within_reg;
        remaining_next = remaining_reg;
        dest_next      = dest_reg;
        left_next      = left_reg;
        tbl_ctl.wr_en  = 1'b0;
        tbl_ctl.rd_en  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.command == CMD_LOAD)
                    begin
                        // slots past the table are dropped
                        tbl_ctl.wr_en = (idx_ext < BYTE_W'(TABLE_DEPTH));
                    end
                    else
                    begin
                        offset_next = req.offset;
                        length_next = req.length;
                        end_next    = {1'b0, req.offset} + {1'b0, req.length};
                        state_next  = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                // stream bound first, then block span
                if (end_reg > {1'b0, cfg.stream_size})
                begin
                    err_next   = STATUS_STREAM;
                    state_next = ST_ERROR;
                end
                else
                begin
                    first_next    = offset_reg >> cfg.lg;
                    last_blk_next = end_byte >> cfg.lg;
                    state_next    = ST_PLAN;
                end
            end
            ST_PLAN:
            begin
                if (last_blk_reg >= BYTE_W'(TABLE_DEPTH) || span >= BYTE_W'(MAX_SEGMENTS))
                begin
                    err_next   = STATUS_RANGE;
                    state_next = ST_ERROR;
                end
                else
                begin
                    blk_next       = first_reg[AW-1:0];
                    within_next    = offset_reg[WITHIN_W-1:0] & (bsize[WITHIN_W-1:0] - 1'b1);
                    remaining_next = length_reg;
                    dest_next      = '0;
                    left_next      = span[CW-1:0];
                    state_next     = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                tbl_ctl.rd_en = 1'b1;
                state_next    = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_next.data_offset    = phys;
                    out_next.dest_offset    = dest_reg;
                    out_next.segment_length = seg_len;
                    out_next.last           = (left_reg == '0);
                    out_next.status         = STATUS_OK;
                    dest_next               = dest_reg + BYTE_W'(seg_len);
                    remaining_next          = remaining_reg - BYTE_W'(seg_len);
                    within_next             = '0;
                    blk_next                = blk_reg + 1'b1;
                    left_next               = left_reg - 1'b1;
                    state_next              = (left_reg == '0) ? ST_IDLE : ST_FETCH;
                end
            end
            ST_ERROR:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_next.data_offset    = '0;
                    out_next.dest_offset    = '0;
                    out_next.segment_length = '0;
                    out_next.last           = 1'b1;
                    out_next.status         = err_reg;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* tb/block_map_read_segmenter_tb.sv */
// self-checking testbench for block_map_read_segmenter: table loads, read splitting and
// error results, checked against an in-bench translation of each read into segments
// depends on bmrs_pkg and the block_map_read_segmenter rtl only
`timescale 1ns / 1ps

module block_map_read_segmenter_tb;
    import bmrs_pkg::*;

    localparam int unsigned TABLE_ENTRIES = TABLE_DEPTH_DEF;
    localparam int unsigned MAX_SEGS      = MAX_SEGMENTS_DEF;
    localparam int unsigned QUIET_LIMIT   = 4000;
    localparam int unsigned PHASE_ITEMS   = 68;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [PADDR_W-1:0]   paddr     = '0;
    logic [PDATA_W-1:0]   pwdata    = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    req_t                 req       = '0;
    logic                 seg_valid;
    logic                 seg_ready = 1'b0;
    seg_t                 seg;

    // items waiting for the driver, with a flag that holds an item until all is drained
    req_t                 commands[$];
    bit                   hold_marks[$];
    bit                   hold_next = 1'b0;
    // segments owed by the block, oldest first
    seg_t                 segments_due[$];

    // shadow of the block state as the bench sees it
    logic [BLOCK_W-1:0]   block_map[0:TABLE_ENTRIES-1];
    bit                   entry_loaded[0:TABLE_ENTRIES-1];
    logic [LG_W-1:0]      shift_lg     = LG_RESET;
    logic [BYTE_W-1:0]    stream_bytes = STREAM_RESET;

    bit                   req_beat;
    bit                   seg_beat;
    bit                   next_valid;
    req_t                 next_req;
    bit                   src_idle_en  = 1'b1;
    bit                   sink_idle_en = 1'b1;
    int unsigned          src_gap      = 0;
    int unsigned          sink_gap     = 0;
    int unsigned          quiet_cycles = 0;
    int unsigned          mismatch_count = 0;
    int unsigned          items_queued = 0;

    block_map_read_segmenter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .seg_valid (seg_valid),
        .seg_ready (seg_ready),
        .seg       (seg)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // block size shift as the block applies it
    function automatic int unsigned eff_lg();
        return (shift_lg > LG_MAX) ? LG_MAX : shift_lg;
    endfunction

    // expected segments of one read under the current settings
    task automatic translate_read(input req_t r);
        logic [32:0]  span_end;
        logic [31:0]  first_blk, last_blk, nsegs, bsize, blk_off, left, dest, room, take;
        int unsigned  lg, k;
        seg_t         s;
        lg       = eff_lg();
        span_end = {1'b0, r.offset} + {1'b0, r.length};
        s        = '0;
        s.last   = 1'b1;
        if (span_end > {1'b0, stream_bytes})
        begin
            s.status = STATUS_STREAM;
            segments_due.push_back(s);
            return;
        end
        first_blk = r.offset >> lg;
        last_blk  = (r.length == 0) ? first_blk : 32'((span_end - 33'd1) >> lg);
        nsegs     = last_blk - first_blk + 1;
        if (last_blk >= TABLE_ENTRIES || nsegs > MAX_SEGS)
        begin
            s.status = STATUS_RANGE;
            segments_due.push_back(s);
            return;
        end
        bsize   = 32'd1 << lg;
        blk_off = r.offset & (bsize - 1);
        left    = r.length;
        dest    = 0;
        for (k = 0; k < nsegs; k++)
        begin
            room = bsize - ((k == 0) ? blk_off : 32'd0);
            take = (left < room) ? left : room;
            s.data_offset    = ({16'b0, block_map[first_blk + k]} << lg)
                               + {4'b0, ((k == 0) ? blk_off : 32'd0)};
            s.dest_offset    = dest;
            s.segment_length = take[SEGLEN_W-1:0];
            s.last           = (k + 1 == nsegs);
            s.status         = STATUS_OK;
            segments_due.push_back(s);
            dest = dest + take;
            left = left - take;
        end
    endtask

    // compare one result beat with the oldest owed segment
    task automatic compare_segment(input seg_t got);
        seg_t want;
        if (segments_due.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected segment: data %h dest %h len %0d last %b status %0d",
                         got.data_offset, got.dest_offset, got.segment_length,
                         got.last, got.status);
        end
        else
        begin
            want = segments_due.pop_front();
            if (got.data_offset !== want.data_offset || got.dest_offset !== want.dest_offset
                || got.segment_length !== want.segment_length || got.last !== want.last
                || got.status !== want.status)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display({"segment mismatch: expected data %h dest %h len %0d last %b ",
                              "status %0d, got data %h dest %h len %0d last %b status %0d"},
                             want.data_offset, want.dest_offset, want.segment_length,
                             want.last, want.status, got.data_offset, got.dest_offset,
                             got.segment_length, got.last, got.status);
            end
        end
    endtask

    // sample both channels, predict on request beats, check result beats, watchdog
    always @(posedge clk)
    begin
        req_beat = req_valid && req_ready;
        seg_beat = seg_valid && seg_ready;
        if (req_beat)
        begin
            if (req.command == CMD_LOAD)
                block_map[req.entry_index] = req.block_number;
            else
                translate_read(req);
        end
        if (seg_beat)
            compare_segment(seg);
        if (req_beat || seg_beat)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // request driver: next item after a beat, with random gaps and the drain hold
    always @(negedge clk)
    begin
        next_valid = req_valid && !req_beat;
        next_req   = req;
        if (!next_valid)
        begin
            if (src_gap != 0)
                src_gap--;
            else if (commands.size() != 0 && !(hold_marks[0] && segments_due.size() != 0))
            begin
                next_req   = commands.pop_front();
                void'(hold_marks.pop_front());
                next_valid = 1'b1;
                if (src_idle_en && $urandom_range(0, 4) == 0)
                    src_gap = $urandom_range(1, 12);
            end
        end
        req_valid <= next_valid;
        req       <= next_req;
    end

    // result sink: ready with random stall bursts
    always @(negedge clk)
    begin
        if (sink_gap != 0)
        begin
            sink_gap--;
            seg_ready <= 1'b0;
        end
        else if (sink_idle_en && $urandom_range(0, 5) == 0)
        begin
            sink_gap = $urandom_range(0, 11);
            seg_ready <= 1'b0;
        end
        else
            seg_ready <= 1'b1;
    end

    task automatic push_item(input req_t item);
        commands.push_back(item);
        hold_marks.push_back(hold_next);
        hold_next = 1'b0;
        items_queued++;
    endtask

    task automatic queue_load(input logic [IDX_W-1:0] idx, input logic [BLOCK_W-1:0] bnum);
        req_t item;
        item.command      = CMD_LOAD;
        item.entry_index  = idx;
        item.block_number = bnum;
        item.offset       = $urandom;
        item.length       = $urandom;
        entry_loaded[idx] = 1'b1;
        push_item(item);
    endtask

    // a read, preceded by loads of any untouched entry it would walk through
    task automatic queue_read(input logic [31:0] off, input logic [31:0] len);
        logic [32:0]  span_end;
        logic [31:0]  first_blk, last_blk;
        int unsigned  blk;
        req_t         item;
        span_end  = {1'b0, off} + {1'b0, len};
        first_blk = off >> eff_lg();
        last_blk  = (len == 0) ? first_blk : 32'((span_end - 33'd1) >> eff_lg());
        if (span_end <= {1'b0, stream_bytes} && last_blk < TABLE_ENTRIES
            && last_blk - first_blk < MAX_SEGS)
            for (blk = first_blk; blk <= last_blk; blk++)
                if (!entry_loaded[blk])
                    queue_load(blk[IDX_W-1:0], BLOCK_W'($urandom_range(0, 20'hFFFFF)));
        item.command      = CMD_READ;
        item.entry_index  = IDX_W'($urandom_range(0, TABLE_ENTRIES - 1));
        item.block_number = BLOCK_W'($urandom_range(0, 20'hFFFFF));
        item.offset       = off;
        item.length       = len;
        push_item(item);
    endtask

    // a length that ends in the segs-th block counted from the start block
    function automatic logic [31:0] span_bytes(input int unsigned segs,
                                               input logic [31:0] blk_off,
                                               input logic [31:0] bsize);
        logic [31:0] lo, hi;
        lo = (segs == 1) ? 32'd1 : (segs - 1) * bsize - blk_off + 1;
        hi = segs * bsize - blk_off;
        case ($urandom_range(0, 3))
            0:       return lo;
            1:       return hi;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    task automatic queue_random_item();
        logic [31:0]  bsize, blk_off, off, len;
        int unsigned  segs, first_blk, pick;
        pick    = $urandom_range(0, 19);
        bsize   = 32'd1 << eff_lg();
        blk_off = $urandom & (bsize - 1);
        if (pick < 3)
            queue_load(IDX_W'($urandom_range(0, TABLE_ENTRIES - 1)),
                       BLOCK_W'($urandom_range(0, 20'hFFFFF)));
        else if (pick < 15)
        begin
            // well-formed read over loaded blocks
            if ($urandom_range(0, 7) == 0)
                segs = ($urandom_range(0, 1) == 0) ? MAX_SEGS : $urandom_range(1, MAX_SEGS);
            else
                segs = $urandom_range(1, 4);
            first_blk = $urandom_range(0, TABLE_ENTRIES - segs);
            off = first_blk * bsize + blk_off;
            len = ($urandom_range(0, 15) == 0) ? 32'd0 : span_bytes(segs, blk_off, bsize);
            queue_read(off, len);
        end
        else if (pick < 18)
            queue_read($urandom, $urandom);
        else
        begin
            // too many segments, or a walk off the end of the table
            if ($urandom_range(0, 1) == 0)
            begin
                segs      = $urandom_range(MAX_SEGS + 1, MAX_SEGS + 16);
                first_blk = $urandom_range(0, TABLE_ENTRIES - 1);
            end
            else
            begin
                segs      = $urandom_range(1, 4);
                first_blk = $urandom_range(TABLE_ENTRIES - 2, TABLE_ENTRIES + 63);
            end
            off = first_blk * bsize + blk_off;
            queue_read(off, span_bytes(segs, blk_off, bsize));
        end
    endtask

    task automatic queue_random(input int unsigned count);
        int unsigned start;
        start = items_queued;
        while (items_queued - start < count)
            queue_random_item();
    endtask

    // apb write: setup then access beat
    task automatic write_reg(input logic idx, input logic [31:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (idx == REG_BLOCK_SIZE_LOG2)
            shift_lg = value[LG_W-1:0];
        else
            stream_bytes = value;
    endtask

    // wait until every item is taken and every owed segment has come, then let it settle
    task automatic settle(input int unsigned cycles);
        while (commands.size() != 0 || req_valid)
            @(posedge clk);
        while (segments_due.size() != 0)
            @(posedge clk);
        repeat (cycles) @(posedge clk);
    endtask

    task automatic start_phase(input logic [LG_W-1:0] lg, input logic [31:0] stream_len,
                               input bit src_idle, input bit sink_idle);
        settle(16);
        write_reg(REG_BLOCK_SIZE_LOG2, {27'b0, lg});
        write_reg(REG_STREAM_SIZE, stream_len);
        src_idle_en  = src_idle;
        sink_idle_en = sink_idle;
        @(posedge clk);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // reset settings: empty stream, 4 KiB blocks
        queue_load(0, 20'hFFFFF);
        queue_read(0, 0);
        queue_read(0, 1);
        queue_read(32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // 16-byte blocks over the widest stream
        start_phase(5'd4, 32'hFFFF_FFFF, 1'b1, 1'b1);
        queue_load(IDX_W'(TABLE_ENTRIES - 1), 20'h00000);
        queue_read((TABLE_ENTRIES - 1) * 16 + 3, 13);
        queue_read((TABLE_ENTRIES - 1) * 16, 16);
        queue_read(15, 2);
        queue_read(0, (MAX_SEGS + 1) * 16);
        queue_read(TABLE_ENTRIES * 16, 0);
        queue_read((TABLE_ENTRIES - 1) * 16, 17);
        queue_read(32'hFFFF_FFFF, 1);
        queue_read(0, 32'hFFFF_FFFF);
        queue_read(32'hFFFF_FFFF, 0);
        queue_load(2, 20'h5A5A5);
        queue_read(40, 0);
        queue_random(PHASE_ITEMS);

        // byte blocks with a short stream; one item waits for a full drain
        start_phase(5'd0, 32'd1000, 1'b1, 1'b1);
        queue_read(990, 10);
        queue_read(990, 11);
        queue_random(PHASE_ITEMS / 2);
        hold_next = 1'b1;
        queue_random(PHASE_ITEMS - PHASE_ITEMS / 2);

        // largest blocks, sender never idles
        start_phase(LG_MAX, 32'hFFFF_FFFF, 1'b0, 1'b1);
        queue_random(PHASE_ITEMS);

        // oversized shift, clamped to the largest block
        start_phase(5'd31, $urandom_range(32'h0010_0000, 32'hFFFF_FFFF), 1'b1, 1'b1);
        queue_random(PHASE_ITEMS);

        // random block size, no idling on either side
        start_phase(LG_W'($urandom_range(1, 15)), $urandom, 1'b0, 1'b0);
        queue_random(PHASE_ITEMS);

        settle(150);
        if (mismatch_count == 0 && segments_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
